// ----- design/dagm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dagm_pkg: shared types and constants
// Field widths, command codes and the controller-to-datapath command bundle.
// ----------------------------------------------------------------------------
package dagm_pkg;

  localparam int unsigned ROW_W = 64;
  localparam int unsigned IDX_W = 6;
  localparam int unsigned CFG_W = 7;

  localparam logic [CFG_W-1:0] VCOUNT_RESET = 7'd64;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  typedef struct packed {
    logic wr_en;    // store one adjacency row
    logic rd_en;    // read a row into the read register
    logic capture;  // read data is row k: seed current row and accumulator
    logic merge;    // read data is row p: fold into accumulator bit p
    logic emit;     // drive the finished row onto the result ports
    logic last;     // emitted row is the final one
  } dp_cmd_t;

endpackage

// ----- design/dag_moralization.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dag_moralization: moral graph of a directed graph
// Stores adjacency rows, then on a compute request emits the moral graph,
// one row per vertex in use, in vertex order.
// ----------------------------------------------------------------------------
//  channel   signals                                   handshake
//  request   start_i, operation_i, row_index_i,        start_i & !busy_o
//            row_bits_i
//  result    out_row_index_o, out_row_bits_o,          out_valid_o, one cycle
//            last_row_o
//  config    cfg_data_i                                cfg_valid_i & cfg_ready_o
//
//  A load request writes the row store straight from idle and busy_o stays low.
//  A compute request takes each row k in use in turn: it issues the read of
//  row k, captures it, runs one merge per scanned row p through the single
//  read port of the row store, and ends with an emit.
//  Results leave one per row; the receiver cannot stall them.
//  Reset clears the sequencer and sets the vertex count to 64; the row store
//  is not cleared.
// ----------------------------------------------------------------------------
module dag_moralization #(
  parameter int unsigned MAX_VERTICES = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic                        operation_i,
  input  logic [dagm_pkg::IDX_W-1:0]  row_index_i,
  input  logic [dagm_pkg::ROW_W-1:0]  row_bits_i,
  output logic                        out_valid_o,
  output logic [dagm_pkg::IDX_W-1:0]  out_row_index_o,
  output logic [dagm_pkg::ROW_W-1:0]  out_row_bits_o,
  output logic                        last_row_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [dagm_pkg::CFG_W-1:0]  cfg_data_i
);
  import dagm_pkg::*;

  localparam int unsigned AW = $clog2(MAX_VERTICES);

  dp_cmd_t       cmd;
  logic [AW-1:0] rd_addr, row_sel, scan_sel, last_idx;

  assign cfg_ready_o = 1'b1;

  dagm_ctrl #(
    .MAX_VERTICES (MAX_VERTICES),
    .AW           (AW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .operation_i (operation_i),
    .last_idx_i  (last_idx),
    .busy_o      (busy_o),
    .cmd_o       (cmd),
    .rd_addr_o   (rd_addr),
    .row_sel_o   (row_sel),
    .scan_sel_o  (scan_sel)
  );

  dagm_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .AW           (AW)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .rd_addr_i       (rd_addr),
    .row_sel_i       (row_sel),
    .scan_sel_i      (scan_sel),
    .row_index_i     (row_index_i),
    .row_bits_i      (row_bits_i),
    .cfg_we_i        (cfg_valid_i & cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .last_idx_o      (last_idx),
    .out_valid_o     (out_valid_o),
    .out_row_index_o (out_row_index_o),
    .out_row_bits_o  (out_row_bits_o),
    .last_row_o      (last_row_o)
  );

endmodule

// ----- design/dagm_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dagm_datapath: adjacency memory and row accumulator
// Holds the row store, the vertex count register, the current row and the
// moral accumulator, and the registered result ports.
// ----------------------------------------------------------------------------
module dagm_datapath #(
  parameter int unsigned MAX_VERTICES = 64,
  parameter int unsigned AW           = $clog2(MAX_VERTICES)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dagm_pkg::dp_cmd_t           cmd_i,
  input  logic [AW-1:0]               rd_addr_i,
  input  logic [AW-1:0]               row_sel_i,
  input  logic [AW-1:0]               scan_sel_i,
  input  logic [dagm_pkg::IDX_W-1:0]  row_index_i,
  input  logic [dagm_pkg::ROW_W-1:0]  row_bits_i,
  input  logic                        cfg_we_i,
  input  logic [dagm_pkg::CFG_W-1:0]  cfg_data_i,
  output logic [AW-1:0]               last_idx_o,
  output logic                        out_valid_o,
  output logic [dagm_pkg::IDX_W-1:0]  out_row_index_o,
  output logic [dagm_pkg::ROW_W-1:0]  out_row_bits_o,
  output logic                        last_row_o
);
  import dagm_pkg::*;

  logic [ROW_W-1:0] mem [MAX_VERTICES];
  logic [ROW_W-1:0] rd_data_q;
  logic [ROW_W-1:0] cur_q, acc_q, acc_d;
  logic [CFG_W-1:0] vcount_q;
  logic [CFG_W-1:0] n_act;
  logic [ROW_W-1:0] mask;
  logic [ROW_W-1:0] self_bit;
  logic             wr_ok;
  logic             out_valid_q, last_q;
  logic [IDX_W-1:0] out_idx_q;
  logic [ROW_W-1:0] out_bits_q;

  // vertices in use: zero counts as one, saturate at the store depth
  always_comb begin
    if (vcount_q == '0) begin
      n_act = CFG_W'(1);
    end else if (vcount_q > CFG_W'(MAX_VERTICES)) begin
      n_act = CFG_W'(MAX_VERTICES);
    end else begin
      n_act = vcount_q;
    end
  end

  assign last_idx_o = AW'(n_act - CFG_W'(1));

  always_comb begin
    for (int j = 0; j < ROW_W; j++) begin
      mask[j] = (CFG_W'(j) < n_act);
    end
  end

  assign self_bit = ROW_W'(1) << row_sel_i;
  assign wr_ok    = ({1'b0, row_index_i} < CFG_W'(MAX_VERTICES));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= VCOUNT_RESET;
    end else if (cfg_we_i) begin
      vcount_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && wr_ok) begin
      mem[row_index_i[AW-1:0]] <= row_bits_i;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  // row p joins k when it points at k or shares a child with k
  always_comb begin
    acc_d = acc_q;
    if (cmd_i.capture) begin
      acc_d = rd_data_q & mask;
    end else if (cmd_i.merge) begin
      acc_d[scan_sel_i] = acc_q[scan_sel_i] | (|(rd_data_q & cur_q)) | rd_data_q[row_sel_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cur_q <= rd_data_q & mask;
    end
    acc_q <= acc_d;
    if (cmd_i.emit) begin
      out_idx_q  <= IDX_W'(row_sel_i);
      out_bits_q <= acc_q & mask & ~self_bit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      out_valid_q <= cmd_i.emit;
      last_q      <= cmd_i.emit & cmd_i.last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_row_index_o = out_idx_q;
  assign out_row_bits_o  = out_bits_q;
  assign last_row_o      = last_q;

endmodule

// ----- design/dagm_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dagm_ctrl: scan sequencer
// Walks row k over the vertices in use and, for each, scans every row p in use.
// ----------------------------------------------------------------------------
module dagm_ctrl #(
  parameter int unsigned MAX_VERTICES = 64,
  parameter int unsigned AW           = $clog2(MAX_VERTICES)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              operation_i,
  input  logic [AW-1:0]     last_idx_i,
  output logic              busy_o,
  output dagm_pkg::dp_cmd_t cmd_o,
  output logic [AW-1:0]     rd_addr_o,
  output logic [AW-1:0]     row_sel_o,
  output logic [AW-1:0]     scan_sel_o
);
  import dagm_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RDK  = 3'd1;
  localparam logic [2:0] S_CAPK = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [AW-1:0] k_q, k_d;
  logic [AW-1:0] p_q, p_d;

  always_comb begin
    state_d   = state_q;
    k_d       = k_q;
    p_d       = p_q;
    cmd_o     = '0;
    rd_addr_o = k_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (operation_i == OP_COMPUTE) begin
            k_d     = '0;
            state_d = S_RDK;
          end else begin
            cmd_o.wr_en = 1'b1;
          end
        end
      end
      S_RDK: begin
        cmd_o.rd_en = 1'b1;
        rd_addr_o   = k_q;
        state_d     = S_CAPK;
      end
      S_CAPK: begin
        cmd_o.capture = 1'b1;
        cmd_o.rd_en   = 1'b1;
        rd_addr_o     = '0;
        p_d           = '0;
        state_d       = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.merge = 1'b1;
        if (p_q == last_idx_i) begin
          state_d = S_EMIT;
        end else begin
          cmd_o.rd_en = 1'b1;
          rd_addr_o   = p_q + AW'(1);
          p_d         = p_q + AW'(1);
        end
      end
      S_EMIT: begin
        cmd_o.emit = 1'b1;
        cmd_o.last = (k_q == last_idx_i);
        if (k_q == last_idx_i) begin
          k_d     = '0;
          state_d = S_IDLE;
        end else begin
          k_d     = k_q + AW'(1);
          state_d = S_RDK;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      k_q     <= '0;
      p_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      p_q     <= p_d;
    end
  end

  assign busy_o     = (state_q != S_IDLE);
  assign row_sel_o  = k_q;
  assign scan_sel_o = p_q;

endmodule

// ----- design/dagm_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dagm_checker: port-level checks
// Watches the top-level ports for sequencing and result-shape slips.
// ----------------------------------------------------------------------------
module dagm_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start_i,
  input logic                        busy_o,
  input logic                        operation_i,
  input logic                        out_valid_o,
  input logic [dagm_pkg::IDX_W-1:0]  out_row_index_o,
  input logic [dagm_pkg::ROW_W-1:0]  out_row_bits_o,
  input logic                        last_row_o
);
  import dagm_pkg::*;

  // results only come out of a running compute
  a_out_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $past(busy_o))
    else $error("result without a running compute");

  a_last_marks_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_row_o |-> out_valid_o)
    else $error("last_row_o without a result");

  a_no_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |=> !out_valid_o)
    else $error("results in adjacent cycles");

  a_compute_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && operation_i == OP_COMPUTE) |=> busy_o)
    else $error("compute request not started");

  a_clear_diagonal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !out_row_bits_o[out_row_index_o])
    else $error("diagonal bit set in result row");

endmodule

bind dag_moralization dagm_checker u_dagm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start_i         (start_i),
  .busy_o          (busy_o),
  .operation_i     (operation_i),
  .out_valid_o     (out_valid_o),
  .out_row_index_o (out_row_index_o),
  .out_row_bits_o  (out_row_bits_o),
  .last_row_o      (last_row_o)
);

// ----- bench/tb_dag_moralization.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dag_moralization: self-checking bench for the moral graph block
// Loads adjacency rows and issues compute requests under several vertex
// counts and sender idle rates. The bench keeps its own copy of the row
// store and of the vertex count, derives every moral graph row on each
// compute request and checks the emitted rows in order.
// ----------------------------------------------------------------------------
module tb_dag_moralization;
  import dagm_pkg::*;

  localparam int unsigned MAX_V     = 64;
  localparam int unsigned LIMIT     = 5_000_000;
  localparam int unsigned MAX_GAP   = 20;
  localparam int unsigned PHASE_LEN = 15;

  typedef struct {
    logic [IDX_W-1:0] idx;
    logic [ROW_W-1:0] bits;
    logic             last;
  } moral_row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             start_i;
  logic             busy_o;
  logic             operation_i;
  logic [IDX_W-1:0] row_index_i;
  logic [ROW_W-1:0] row_bits_i;
  logic             out_valid_o;
  logic [IDX_W-1:0] out_row_index_o;
  logic [ROW_W-1:0] out_row_bits_o;
  logic             last_row_o;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [CFG_W-1:0] cfg_data_i;

  logic [ROW_W-1:0] adj_rows [MAX_V];
  logic [CFG_W-1:0] vcount_q;
  moral_row_t       expected_moral_rows [$];
  moral_row_t       head;
  int unsigned      idle_pct;
  int unsigned      mismatch_count;
  int unsigned      cycle_count;

  dag_moralization #(
    .MAX_VERTICES(MAX_V)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .operation_i    (operation_i),
    .row_index_i    (row_index_i),
    .row_bits_i     (row_bits_i),
    .out_valid_o    (out_valid_o),
    .out_row_index_o(out_row_index_o),
    .out_row_bits_o (out_row_bits_o),
    .last_row_o     (last_row_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic int unsigned vertices_in_use();
    if (vcount_q == 0) return 1;
    if (vcount_q > MAX_V) return MAX_V;
    return vcount_q;
  endfunction

  function automatic void predict_moral_graph();
    int unsigned      n;
    logic [ROW_W-1:0] mask;
    logic [ROW_W-1:0] cur;
    logic [ROW_W-1:0] acc;
    logic [ROW_W-1:0] masked  [MAX_V];
    logic [ROW_W-1:0] parents [MAX_V];
    moral_row_t       r;
    n = vertices_in_use();
    mask = (n >= ROW_W) ? '1 : ((64'd1 << n) - 64'd1);
    for (int k = 0; k < n; k++) masked[k] = adj_rows[k] & mask;
    // column v of the masked matrix: every parent of v
    for (int v = 0; v < n; v++) begin
      parents[v] = '0;
      for (int p = 0; p < n; p++) if (masked[p][v]) parents[v][p] = 1'b1;
    end
    for (int k = 0; k < n; k++) begin
      cur = masked[k];
      acc = cur;
      for (int v = 0; v < n; v++) begin
        if (masked[v][k]) acc[v] = 1'b1;
        if (cur[v]) acc |= parents[v];
      end
      r.idx  = k[IDX_W-1:0];
      r.bits = acc & mask & ~(64'd1 << k);
      r.last = (k + 1 == n);
      expected_moral_rows = {expected_moral_rows, r};
    end
  endfunction

  function automatic void apply_request(input logic op, input logic [IDX_W-1:0] idx,
                                        input logic [ROW_W-1:0] bits);
    if (op == OP_LOAD) adj_rows[idx] = bits;
    else predict_moral_graph();
  endfunction

  // ------------------------------------------------------------------ checker

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o) begin
      if (expected_moral_rows.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected row: expected none, actual idx %0d bits %h last %b",
                 $time, out_row_index_o, out_row_bits_o, last_row_o);
      end else begin
        head = expected_moral_rows.pop_front();
        if (out_row_index_o !== head.idx) begin
          mismatch_count++;
          $display("%0t: out_row_index: expected %0d actual %0d",
                   $time, head.idx, out_row_index_o);
        end
        if (out_row_bits_o !== head.bits) begin
          mismatch_count++;
          $display("%0t: out_row_bits row %0d: expected %h actual %h",
                   $time, head.idx, head.bits, out_row_bits_o);
        end
        if (last_row_o !== head.last) begin
          mismatch_count++;
          $display("%0t: last_row row %0d: expected %b actual %b",
                   $time, head.idx, head.last, last_row_o);
        end
      end
    end
  end

  // ---------------------------------------------------------------- drivers

  task automatic send_request(input logic op, input logic [IDX_W-1:0] idx,
                              input logic [ROW_W-1:0] bits);
    int unsigned gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
    @(negedge clk_i);
    if (gap > 0) begin
      start_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i     = 1'b1;
    operation_i = op;
    row_index_i = idx;
    row_bits_i  = bits;
    do @(posedge clk_i); while (busy_o);
    apply_request(op, idx, bits);
  endtask

  task automatic load_row(input int unsigned idx, input logic [ROW_W-1:0] bits);
    send_request(OP_LOAD, idx[IDX_W-1:0], bits);
  endtask

  // compute requests carry junk in the row fields
  task automatic compute_moral();
    send_request(OP_COMPUTE, IDX_W'($urandom_range(63)), {$urandom, $urandom});
  endtask

  // drop start, drain every expected row, then let the sequencer settle
  task automatic drain();
    @(negedge clk_i);
    start_i = 1'b0;
    while (expected_moral_rows.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_vertex_count(input logic [CFG_W-1:0] value);
    drain();
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    vcount_q = value;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    cfg_data_i  = CFG_W'($urandom);
  endtask

  function automatic logic [ROW_W-1:0] random_row();
    logic [ROW_W-1:0] a;
    logic [ROW_W-1:0] b;
    logic [ROW_W-1:0] c;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    c = {$urandom, $urandom};
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2:       return 64'd1 << $urandom_range(63);
      3:       return a;
      4:       return a & b;
      default: return a & b & c;
    endcase
  endfunction

  // ------------------------------------------------------------------- tests

  // fills every row so no later compute can read an unwritten row
  task automatic test_reset_count();
    for (int i = 0; i < MAX_V; i++) begin
      load_row(i, {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom});
    end
    compute_moral();
  endtask

  task automatic test_small_graphs();
    // count of zero acts as one; self loop and high bits vanish
    write_vertex_count(7'd0);
    load_row(0, '1);
    compute_moral();
    write_vertex_count(7'd1);
    compute_moral();
    // 0 and 1 share child 2, chain 2->3, self loop on 3, junk above count
    write_vertex_count(7'd4);
    load_row(0, 64'hFFFF_0000_0000_0004);
    load_row(1, 64'h0000_0000_0000_0004);
    load_row(2, 64'h0000_0000_0000_0008);
    load_row(3, 64'h8000_0000_0000_0008);
    compute_moral();
    // row past the count is kept but unused
    load_row(63, '1);
    compute_moral();
    // loop 0->1->0, no acyclic check
    write_vertex_count(7'd2);
    load_row(0, 64'h2);
    load_row(1, 64'h1);
    compute_moral();
  endtask

  task automatic test_count_saturation();
    write_vertex_count(7'd127);
    compute_moral();
    load_row(63, '0);
    load_row(0, '0);
    write_vertex_count(7'd65);
    compute_moral();
  endtask

  task automatic test_random_phase(input logic [CFG_W-1:0] count, input int unsigned pct);
    int unsigned n;
    write_vertex_count(count);
    idle_pct = pct;
    n = vertices_in_use();
    for (int i = 0; i < PHASE_LEN; i++) begin
      if ($urandom_range(99) < 18) compute_moral();
      else if ($urandom_range(99) < 75) load_row($urandom_range(n - 1), random_row());
      else load_row($urandom_range(63), random_row());
    end
    idle_pct = 0;
  endtask

  initial begin
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    operation_i    = OP_LOAD;
    row_index_i    = '0;
    row_bits_i     = '0;
    cfg_valid_i    = 1'b0;
    cfg_data_i     = '0;
    idle_pct       = 0;
    vcount_q       = VCOUNT_RESET;
    for (int i = 0; i < MAX_V; i++) adj_rows[i] = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_count();
    test_small_graphs();
    test_count_saturation();
    test_random_phase(7'd64, 0);
    test_random_phase(7'd5, 46);
    test_random_phase(7'd23, 0);
    test_random_phase(7'd40, 37);

    drain();
    repeat (16) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
